### rtl/core/stack_machine_execute_defines.svh
// ----------------------------------------------------------------------------
// Stack machine execute: assertion macros
// Shared concurrent assertion helpers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

// Same-cycle implication.
`define SME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine execute package
// Command codes, status codes and the control state type.
// ----------------------------------------------------------------------------
package sme_pkg;

  typedef logic [4:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_PUSH  = 5'd0;
  localparam cmd_t CMD_POP   = 5'd1;
  localparam cmd_t CMD_ADD   = 5'd2;
  localparam cmd_t CMD_SUB   = 5'd3;
  localparam cmd_t CMD_MUL   = 5'd4;
  localparam cmd_t CMD_DIV   = 5'd5;
  localparam cmd_t CMD_PRINT = 5'd6;
  localparam cmd_t CMD_DUP   = 5'd7;
  localparam cmd_t CMD_SWAP  = 5'd8;
  localparam cmd_t CMD_CMPE  = 5'd9;
  localparam cmd_t CMD_CMPNE = 5'd10;
  localparam cmd_t CMD_CMPG  = 5'd11;
  localparam cmd_t CMD_CMPL  = 5'd12;
  localparam cmd_t CMD_CMPGE = 5'd13;
  localparam cmd_t CMD_CMPLE = 5'd14;
  localparam cmd_t CMD_JUMP  = 5'd15;
  localparam cmd_t CMD_HALT  = 5'd16;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_OVER    = 3'd1;
  localparam status_t ST_UNDER   = 3'd2;
  localparam status_t ST_DIVZ    = 3'd3;
  localparam status_t ST_UNK     = 3'd4;
  localparam status_t ST_FAULTED = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_SWAP = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

endpackage

### rtl/core/stack_machine_execute.sv
// ----------------------------------------------------------------------------
// Stack machine execute
// Runs one stack-machine instruction per request on a 32-bit data stack held
// in a synchronous single-port-write memory, with the top entry cached.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | request   | in_valid/in_stall  | in_command, in_operand
// out_    | result    | out_valid/out_stall| out_status .. out_stack_depth
//
// Most commands are accepted (read of the second entry is issued), then
// executed and written back, with the result loaded into the output register.
// Swap makes its two memory writes in turn, as they share the single write port.
// Divide runs a setup step, then 32 radix-2 restoring steps.
// Reset clears depth, fault and control; the stack memory needs no clearing.
// A stalled output holds the block in a wait state until the result is taken.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_defines.svh"

module stack_machine_execute
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_command,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic               out_print_valid,
  output logic               out_jump_taken,
  output logic signed [31:0] out_jump_target,
  output logic               out_halt_seen,
  output logic [10:0]        out_stack_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  // Stack storage: entries 0 .. depth-1, top also cached in top_r.
  logic [31:0] mem [STACK_DEPTH];

  state_t        state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [31:0]   top_r, top_nxt;
  logic          fault_r;
  cmd_t          cmd_r;
  logic [31:0]   opd_r;
  status_t       status_r;
  logic          prt_r, jt_r, halt_r;
  logic [31:0]   rd_data_r;

  // Divider state
  logic [31:0] rem_r, quo_r, den_r;
  logic        neg_r;
  logic [4:0]  cnt_r;

  // Output register
  logic          out_valid_r;
  status_t       out_status_r;
  logic [31:0]   out_top_r, out_target_r;
  logic          out_prt_r, out_jt_r, out_halt_r;
  logic [DW-1:0] out_depth_r;

  logic          accept, out_free, fin, load_out, div_start;
  status_t       acc_status;
  logic          need1, need2, grows;
  logic [AW-1:0] addr_d, addr_m1, addr_m2;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [31:0]   a, b, prod, flag;
  logic [32:0]   shifted, trial;
  logic          qbit;
  logic [31:0]   quo_last, q_final;
  logic [DW+10:0] depth_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Stack addresses relative to the current depth.
  assign addr_d  = depth_r[AW-1:0];
  assign addr_m1 = AW'(depth_r - DW'(1));
  assign addr_m2 = AW'(depth_r - DW'(2));

  assign a = top_r;
  assign b = rd_data_r;
  assign prod = a * b;

  // Radix-2 restoring division step.
  assign shifted  = {rem_r, quo_r[31]};
  assign trial    = shifted - {1'b0, den_r};
  assign qbit     = !trial[32];
  assign quo_last = {quo_r[30:0], qbit};
  assign q_final  = neg_r ? (32'd0 - quo_last) : quo_last;

  // Check the request against the stack before any work starts.
  always_comb begin
    need1 = (in_command == CMD_POP) || (in_command == CMD_PRINT) ||
            (in_command == CMD_DUP) || (in_command == CMD_JUMP);
    need2 = (in_command >= CMD_ADD) && (in_command <= CMD_CMPLE) &&
            (in_command != CMD_PRINT) && (in_command != CMD_DUP);
    grows = (in_command == CMD_PUSH) || (in_command == CMD_DUP) ||
            ((in_command >= CMD_CMPE) && (in_command <= CMD_CMPLE));
    priority if (fault_r) begin
      acc_status = ST_FAULTED;
    end else if (in_command > CMD_HALT) begin
      acc_status = ST_UNK;
    end else if ((need1 && depth_r == '0) || (need2 && depth_r < DW'(2))) begin
      acc_status = ST_UNDER;
    end else if (grows && depth_r >= DW'(STACK_DEPTH)) begin
      acc_status = ST_OVER;
    end else if (in_command == CMD_DIV && top_r == 32'd0) begin
      acc_status = ST_DIVZ;
    end else begin
      acc_status = ST_OK;
    end
  end

  // Compare flag: a is the top entry, b the one below.
  always_comb begin
    unique case (cmd_r)
      CMD_CMPE:  flag = {31'd0, a == b};
      CMD_CMPNE: flag = {31'd0, a != b};
      CMD_CMPG:  flag = {31'd0, $signed(a) > $signed(b)};
      CMD_CMPL:  flag = {31'd0, $signed(a) < $signed(b)};
      CMD_CMPGE: flag = {31'd0, $signed(a) >= $signed(b)};
      CMD_CMPLE: flag = {31'd0, $signed(a) <= $signed(b)};
      default:   flag = 32'd0;
    endcase
  end

  // Execute, write back and finish.
  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    top_nxt   = top_r;
    mem_we    = 1'b0;
    mem_wa    = addr_m2;
    mem_wd    = 32'd0;
    fin       = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (status_r != ST_OK) begin
          fin = 1'b1;
        end else begin
          fin = 1'b1;
          unique case (cmd_r)
            CMD_PUSH: begin
              mem_we = 1'b1; mem_wa = addr_d; mem_wd = opd_r;
              top_nxt = opd_r; depth_nxt = depth_r + DW'(1);
            end
            CMD_POP, CMD_JUMP: begin
              top_nxt = b; depth_nxt = depth_r - DW'(1);
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
              mem_we = 1'b1; mem_wa = addr_m2;
              unique case (cmd_r)
                CMD_ADD: mem_wd = b + a;
                CMD_SUB: mem_wd = b - a;
                default: mem_wd = prod;
              endcase
              top_nxt = mem_wd; depth_nxt = depth_r - DW'(1);
            end
            CMD_DIV: begin
              fin = 1'b0; div_start = 1'b1; state_nxt = S_DIV;
            end
            CMD_DUP: begin
              mem_we = 1'b1; mem_wa = addr_d; mem_wd = a;
              depth_nxt = depth_r + DW'(1);
            end
            CMD_SWAP: begin
              // Lower entry now, top entry next cycle.
              mem_we = 1'b1; mem_wa = addr_m2; mem_wd = a;
              top_nxt = b; fin = 1'b0; state_nxt = S_SWAP;
            end
            CMD_CMPE, CMD_CMPNE, CMD_CMPG, CMD_CMPL, CMD_CMPGE, CMD_CMPLE: begin
              mem_we = 1'b1; mem_wa = addr_d; mem_wd = flag;
              top_nxt = flag; depth_nxt = depth_r + DW'(1);
            end
            default: ;
          endcase
        end
      end
      S_SWAP: begin
        mem_we = 1'b1; mem_wa = addr_m1; mem_wd = top_r; fin = 1'b1;
      end
      S_DIV: begin
        if (cnt_r == 5'd31) begin
          mem_we = 1'b1; mem_wa = addr_m2; mem_wd = q_final;
          top_nxt = q_final; depth_nxt = depth_r - DW'(1); fin = 1'b1;
        end
      end
      S_HOLD: fin = 1'b1;
      default: state_nxt = S_IDLE;
    endcase
    load_out = fin && out_free;
    if (fin) state_nxt = out_free ? S_IDLE : S_HOLD;
  end

  // Stack memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (accept) rd_data_r <= mem[addr_m2];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      if (accept && acc_status != ST_OK && acc_status != ST_FAULTED) fault_r <= 1'b1;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload: request, divider and result registers.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (accept) begin
      cmd_r    <= in_command;
      opd_r    <= in_operand;
      status_r <= acc_status;
      prt_r    <= (acc_status == ST_OK) && (in_command == CMD_PRINT);
      jt_r     <= (acc_status == ST_OK) && (in_command == CMD_JUMP) && (top_r == 32'd1);
      halt_r   <= (acc_status == ST_OK) && (in_command == CMD_HALT);
    end
    if (div_start) begin
      rem_r <= 32'd0;
      quo_r <= b[31] ? (32'd0 - b) : b;
      den_r <= a[31] ? (32'd0 - a) : a;
      neg_r <= a[31] ^ b[31];
      cnt_r <= 5'd0;
    end else if (state_r == S_DIV) begin
      rem_r <= qbit ? trial[31:0] : shifted[31:0];
      quo_r <= quo_last;
      cnt_r <= cnt_r + 5'd1;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_top_r    <= (depth_nxt == '0) ? 32'd0 : top_nxt;
      out_prt_r    <= prt_r;
      out_jt_r     <= jt_r;
      out_target_r <= jt_r ? opd_r : 32'd0;
      out_halt_r   <= halt_r;
      out_depth_r  <= depth_nxt;
    end
  end

  assign depth_ext       = {11'd0, out_depth_r};
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_r;
  assign out_print_valid = out_prt_r;
  assign out_jump_taken  = out_jt_r;
  assign out_jump_target = out_target_r;
  assign out_halt_seen   = out_halt_r;
  assign out_stack_depth = depth_ext[10:0];

  `SME_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
  `SME_ASSERT_NEXT(a_fault_sticky, fault_r, fault_r)
  `SME_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DW'(STACK_DEPTH))
  `SME_ASSERT_NOW(a_error_no_flags, out_valid_r && out_status_r != ST_OK,
                  !out_prt_r && !out_jt_r && !out_halt_r)

endmodule

### tb/stack_machine_execute_tb.sv
// ----------------------------------------------------------------------------
// Stack machine execute testbench
// Drives command requests through directed and random phases with random
// idling on both channels, predicts each result from a behavioral stack model
// and checks every result field in order.
// ----------------------------------------------------------------------------
module stack_machine_execute_tb;
  import sme_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] top_value;
    logic        print_valid;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        halt_seen;
    logic [10:0] stack_depth;
  } result_t;

  // Scoreboard: behavioral stack plus a queue of predicted results.
  class stack_scoreboard;
    logic [31:0] words[DEPTH];
    int unsigned depth;
    bit faulted;
    result_t pending[$];
    int errors;

    function void clear();
      depth = 0;
      faulted = 0;
      pending.delete();
      errors = 0;
    endfunction

    function logic [31:0] top_word();
      if (depth == 0) return 32'd0;
      return words[depth - 1];
    endfunction

    function logic [31:0] signed_quot(logic [31:0] num, logic [31:0] den);
      logic [31:0] mn;
      logic [31:0] md;
      logic [31:0] q;
      mn = num[31] ? -num : num;
      md = den[31] ? -den : den;
      q = mn / md;
      if (num[31] ^ den[31]) q = -q;
      return q;
    endfunction

    // Note an accepted request and predict its result.
    function void note_request(logic [4:0] cmd, logic [31:0] opd);
      result_t r;
      int unsigned need;
      bit grows;
      logic [31:0] a;
      logic [31:0] b;
      r = '{default: '0};
      a = 0;
      b = 0;
      if (faulted) r.status = ST_FAULTED;
      else if (cmd > CMD_HALT) r.status = ST_UNK;
      else begin
        if (cmd == CMD_PUSH || cmd == CMD_HALT) need = 0;
        else if (cmd == CMD_POP || cmd == CMD_PRINT || cmd == CMD_DUP || cmd == CMD_JUMP)
          need = 1;
        else need = 2;
        grows = cmd == CMD_PUSH || cmd == CMD_DUP || (cmd >= CMD_CMPE && cmd <= CMD_CMPLE);
        if (depth < need) r.status = ST_UNDER;
        else if (grows && depth >= DEPTH) r.status = ST_OVER;
        else begin
          if (need >= 1) a = words[depth - 1];
          if (need >= 2) b = words[depth - 2];
          if (cmd == CMD_DIV && a == 0) r.status = ST_DIVZ;
        end
      end
      if (r.status == ST_OK) begin
        case (cmd)
          CMD_PUSH: begin words[depth] = opd; depth++; end
          CMD_POP: depth--;
          CMD_ADD: begin words[depth - 2] = b + a; depth--; end
          CMD_SUB: begin words[depth - 2] = b - a; depth--; end
          CMD_MUL: begin words[depth - 2] = b * a; depth--; end
          CMD_DIV: begin words[depth - 2] = signed_quot(b, a); depth--; end
          CMD_PRINT: r.print_valid = 1;
          CMD_DUP: begin words[depth] = a; depth++; end
          CMD_SWAP: begin words[depth - 1] = b; words[depth - 2] = a; end
          CMD_CMPE: begin words[depth] = {31'd0, a == b}; depth++; end
          CMD_CMPNE: begin words[depth] = {31'd0, a != b}; depth++; end
          CMD_CMPG: begin words[depth] = {31'd0, $signed(a) > $signed(b)}; depth++; end
          CMD_CMPL: begin words[depth] = {31'd0, $signed(a) < $signed(b)}; depth++; end
          CMD_CMPGE: begin words[depth] = {31'd0, $signed(a) >= $signed(b)}; depth++; end
          CMD_CMPLE: begin words[depth] = {31'd0, $signed(a) <= $signed(b)}; depth++; end
          CMD_JUMP: begin
            depth--;
            if (a == 32'd1) begin
              r.jump_taken = 1;
              r.jump_target = opd;
            end
          end
          default: r.halt_seen = 1;
        endcase
      end else if (r.status != ST_FAULTED) begin
        faulted = 1;
      end
      r.top_value = top_word();
      r.stack_depth = depth[10:0];
      pending.push_back(r);
    endfunction

    // Compare one accepted result against the oldest prediction.
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.top_value !== exp_r.top_value) begin
        $display("%0t: top_value exp %h got %h", $time, exp_r.top_value, got.top_value);
        errors++;
      end
      if (got.print_valid !== exp_r.print_valid) begin
        $display("%0t: print_valid exp %b got %b", $time, exp_r.print_valid,
                 got.print_valid);
        errors++;
      end
      if (got.jump_taken !== exp_r.jump_taken) begin
        $display("%0t: jump_taken exp %b got %b", $time, exp_r.jump_taken, got.jump_taken);
        errors++;
      end
      if (got.jump_target !== exp_r.jump_target) begin
        $display("%0t: jump_target exp %h got %h", $time, exp_r.jump_target,
                 got.jump_target);
        errors++;
      end
      if (got.halt_seen !== exp_r.halt_seen) begin
        $display("%0t: halt_seen exp %b got %b", $time, exp_r.halt_seen, got.halt_seen);
        errors++;
      end
      if (got.stack_depth !== exp_r.stack_depth) begin
        $display("%0t: stack_depth exp %0d got %0d", $time, exp_r.stack_depth,
                 got.stack_depth);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [4:0]         in_command;
  logic signed [31:0] in_operand;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic signed [31:0] out_top_value;
  logic               out_print_valid;
  logic               out_jump_taken;
  logic signed [31:0] out_jump_target;
  logic               out_halt_seen;
  logic [10:0]        out_stack_depth;

  stack_scoreboard board;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;
  bit timed_out;

  stack_machine_execute #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_operand(in_operand),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_top_value(out_top_value),
    .out_print_valid(out_print_valid), .out_jump_taken(out_jump_taken),
    .out_jump_target(out_jump_target), .out_halt_seen(out_halt_seen),
    .out_stack_depth(out_stack_depth)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: randomly stall, check every accepted result, and run the
  // watchdog on cycles where neither channel moves a request or result.
  initial begin
    out_stall = 0;
    quiet_cycles = 0;
    timed_out = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && !out_stall)
          board.check_result('{out_status, out_top_value, out_print_valid,
                               out_jump_taken, out_jump_target, out_halt_seen,
                               out_stack_depth});
        if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one request: optionally idle first, then hold it until accepted.
  // Valid stays high after acceptance so the next request can follow at once.
  task automatic send_request(logic [4:0] cmd, logic [31:0] opd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_operand <= opd;
    do @(posedge clk); while (in_stall);
    board.note_request(cmd, opd);
  endtask

  // Drop valid and hold the sender until every predicted result has come back.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // Clear a fault by reset is not allowed, so random programs avoid errors
  // until the very end; pick an operation that is legal for the current depth.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_legal_op();
    logic [4:0] cmd;
    int unsigned d;
    d = board.depth;
    if (d == 0) cmd = ($urandom_range(9) == 0) ? CMD_HALT : CMD_PUSH;
    else if (d >= DEPTH - 1) cmd = CMD_POP;
    else begin
      cmd = 5'($urandom_range(16));
      if (d < 2 && cmd >= CMD_ADD && cmd <= CMD_CMPLE && cmd != CMD_PRINT &&
          cmd != CMD_DUP)
        cmd = CMD_PUSH;
      // Grow the stack more often than it shrinks when shallow.
      if (d < 8 && $urandom_range(2) == 0) cmd = CMD_PUSH;
      if (cmd == CMD_DIV && board.words[d - 1] == 0) cmd = CMD_ADD;
    end
    // Make jumps taken about half the time by priming a 0 or 1 on top.
    if (cmd == CMD_JUMP) begin
      send_request(CMD_PUSH, $urandom_range(1));
      if (board.faulted) return;
    end
    send_request(cmd, rand_word());
  endtask

  initial begin
    int phase;
    board = new();
    board.clear();
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_PUSH;
    in_operand = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    fork
      begin
        // Directed: underflows are faults, so probe each error at the end.
        send_request(CMD_HALT, 32'd0);
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_PUSH, 32'hffff_ffff);
        send_request(CMD_DIV, 32'd0);            // most negative over minus one
        send_request(CMD_PUSH, 32'h7fff_ffff);
        send_request(CMD_MUL, 32'd0);
        send_request(CMD_PUSH, 32'd7);
        send_request(CMD_SUB, 32'd0);
        send_request(CMD_PUSH, 32'hffff_fffd);
        send_request(CMD_DIV, 32'd0);            // truncate toward zero
        send_request(CMD_DUP, 32'd0);
        send_request(CMD_SWAP, 32'd0);
        for (int c = CMD_CMPE; c <= CMD_CMPLE; c++) send_request(c[4:0], 32'd0);
        send_request(CMD_PRINT, 32'd0);
        send_request(CMD_JUMP, 32'h1234_5678);
        send_request(CMD_PUSH, 32'd1);
        send_request(CMD_JUMP, 32'hdead_beef);   // taken
        send_request(CMD_ADD, 32'd0);
        drain();

        // Random programs through the idling phases.
        for (phase = 0; phase < 4 && !timed_out; phase++) begin
          send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 47 : 37) : 0;
          stall_pct = (phase == 2) ? 47 : ((phase == 3) ? 37 : 0);
          for (int i = 0; i < 220 && !timed_out; i++) begin
            random_legal_op();
            if ($urandom_range(150) == 0) drain();
          end
          drain();
        end

        // Fill to the top, overflow, then confirm the sticky fault.
        send_idle_pct = 0;
        stall_pct = 10;
        while (board.depth < DEPTH && !timed_out) send_request(CMD_PUSH, $urandom);
        send_request(CMD_DUP, 32'd0);
        send_request(CMD_PUSH, 32'd5);
        send_request(5'($urandom_range(31, 17)), $urandom);
        drain();
        send_request(5'd31, 32'd0);
        drain();
      end
      begin
        wait (timed_out);
      end
    join_any
    repeat (50) @(posedge clk);
    if (timed_out || board.pending.size() != 0 || board.errors != 0)
      $display("stack_machine_execute_tb NOT OK");
    else
      $display("stack_machine_execute_tb OK");
    $finish;
  end

endmodule
